// ===== sv/efpf_pkg.sv =====
// shared types, constants and register codes of the encoder frame position filter
package efpf_pkg;

  // framing
  localparam int         MAX_FRAME_BYTES_DEF = 16;
  localparam logic [7:0] START_BYTE          = 8'h47;
  localparam logic [7:0] LINE_FEED           = 8'h0A;
  localparam logic [3:0] STORE_LIMIT         = 4'd15;
  localparam logic [3:0] POS_FIRST           = 4'd2;
  localparam logic [3:0] POS_LAST            = 4'd5;
  localparam logic [3:0] MIN_STORED          = 4'd6;

  // angle range
  localparam logic [18:0] ANGLE_MAX = 19'd360000;

  // configuration port
  localparam int         CFG_DATA_W = 24;
  localparam int         CFG_INDEX_W = 3;
  localparam logic [2:0] REG_AXIS_MODE  = 3'd0;
  localparam logic [2:0] REG_HOME_TICKS = 3'd1;
  localparam logic [2:0] REG_SCALE_Q16  = 3'd2;
  localparam logic [2:0] REG_OFFSET     = 3'd3;
  localparam logic [2:0] REG_WRAP_SPAN  = 3'd4;
  localparam logic [2:0] REG_JUMP_LIMIT = 3'd5;
  localparam logic [2:0] REG_NOISE_TOL  = 3'd6;

  // register reset values
  localparam logic        AXIS_MODE_RST  = 1'b0;
  localparam logic [23:0] HOME_TICKS_RST = 24'd216727;
  localparam logic [23:0] SCALE_Q16_RST  = 24'd323635;
  localparam logic [20:0] OFFSET_RST     = 21'd2697;
  localparam logic [18:0] WRAP_SPAN_RST  = 19'd360000;
  localparam logic [23:0] JUMP_LIMIT_RST = 24'd2000;
  localparam logic [15:0] NOISE_TOL_RST  = 16'd0;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_DEADBAND = 3'd1,
    ST_JUMP     = 3'd2,
    ST_NO_START = 3'd3,
    ST_SHORT    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FR_NO_START = 2'd0,
    FR_SHORT    = 2'd1,
    FR_GOOD     = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_response;
  } byte_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] raw_position;
    logic [31:0] shown_position;
    logic [18:0] angle_mdeg;
  } result_item_t;

  typedef struct packed {
    logic        valid;
    frame_kind_t kind;
    logic [31:0] position;
  } frame_event_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] raw_position;
    logic [31:0] shown_position;
  } filter_out_t;

  typedef struct packed {
    logic        axis_mode;
    logic [23:0] home_ticks;
    logic [23:0] scale_q16;
    logic [20:0] offset_mdeg;
    logic [18:0] wrap_span_mdeg;
    logic [23:0] jump_limit;
    logic [15:0] noise_tolerance;
  } cfg_t;

endpackage

// ===== sv/efpf_frame.sv =====
// frame tracker: start byte hunt, byte storage and position assembly
module efpf_frame #(
  parameter int MAX_FRAME_BYTES = efpf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  efpf_pkg::byte_item_t   byte_data,
  input  logic                   event_ready,
  output efpf_pkg::frame_event_t frame_event
);

  localparam int             CW         = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0]  COUNT_FULL = CW'(MAX_FRAME_BYTES);

  logic [CW-1:0] byte_count, byte_count_next;
  logic [3:0]    stored_count, stored_count_next;
  logic [31:0]   position_bytes, position_bytes_next;
  logic          frame_open, frame_open_next;
  efpf_pkg::frame_event_t frame_event_next;

  logic          accept;
  logic          open_now;
  logic          done;
  logic [CW-1:0] count_base;
  logic [3:0]    stored_base;
  logic [31:0]   pos_base;

  assign byte_stall = frame_event.valid && !event_ready;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    count_base          = byte_data.new_response ? '0 : byte_count;
    stored_base         = byte_data.new_response ? 4'd0 : stored_count;
    pos_base            = byte_data.new_response ? 32'd0 : position_bytes;
    open_now            = byte_data.new_response || frame_open;
    byte_count_next     = byte_count;
    stored_count_next   = stored_count;
    position_bytes_next = position_bytes;
    frame_open_next     = frame_open;
    done                = 1'b0;
    if (open_now) begin
      byte_count_next     = count_base + 1'b1;
      stored_count_next   = stored_base;
      position_bytes_next = pos_base;
      if (byte_data.rx_byte == efpf_pkg::LINE_FEED) begin
        done = 1'b1;
      end else if (stored_base != 4'd0 || byte_data.rx_byte == efpf_pkg::START_BYTE) begin
        if (stored_base >= efpf_pkg::POS_FIRST && stored_base <= efpf_pkg::POS_LAST) begin
          position_bytes_next = {pos_base[23:0], byte_data.rx_byte};
        end
        if (stored_base < efpf_pkg::STORE_LIMIT) begin
          stored_count_next = stored_base + 4'd1;
        end
      end
      if (byte_count_next >= COUNT_FULL) begin
        done = 1'b1;
      end
      frame_open_next = !done;
    end
  end

  always_comb begin
    frame_event_next.valid    = done;
    frame_event_next.position = position_bytes_next;
    if (stored_count_next == 4'd0) begin
      frame_event_next.kind = efpf_pkg::FR_NO_START;
    end else if (stored_count_next < efpf_pkg::MIN_STORED) begin
      frame_event_next.kind = efpf_pkg::FR_SHORT;
    end else begin
      frame_event_next.kind = efpf_pkg::FR_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open        <= 1'b0;
      byte_count        <= COUNT_FULL;
      stored_count      <= 4'd0;
      position_bytes    <= 32'd0;
      frame_event.valid <= 1'b0;
    end else begin
      if (accept) begin
        frame_open     <= frame_open_next;
        byte_count     <= byte_count_next;
        stored_count   <= stored_count_next;
        position_bytes <= position_bytes_next;
        frame_event    <= frame_event_next;
      end else if (event_ready) begin
        frame_event.valid <= 1'b0;
      end
    end
  end

  // an open frame always has room for one more byte
  assert property (@(posedge clk) disable iff (rst)
    frame_open |-> (byte_count < COUNT_FULL))
    else $error("frame open with full byte count");

  // bytes outside a frame are dropped without a frame end
  assert property (@(posedge clk) disable iff (rst)
    accept && !frame_open && !byte_data.new_response |=> !frame_event.valid)
    else $error("frame end raised outside a frame");

  // a decodable frame holds all position bytes
  assert property (@(posedge clk) disable iff (rst)
    frame_event.valid && frame_event.kind == efpf_pkg::FR_GOOD
      |-> stored_count >= efpf_pkg::MIN_STORED)
    else $error("good frame with too few stored bytes");

endmodule

// ===== sv/efpf_filter.sv =====
// jump filter and deadband on decoded positions
module efpf_filter (
  input  logic                   clk,
  input  logic                   rst,
  input  efpf_pkg::cfg_t         cfg,
  input  efpf_pkg::frame_event_t frame_event,
  output logic                   event_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output efpf_pkg::filter_out_t  filter_out
);

  logic [31:0] last_accepted, last_accepted_next;
  logic [31:0] shown_value, shown_value_next;
  efpf_pkg::filter_out_t filter_out_next;

  logic        load;
  logic [31:0] raw;
  logic [31:0] diff_last_raw;
  logic [31:0] diff_shown_raw;
  logic [31:0] diff_shown_last;
  logic [31:0] diff_cand;
  logic [31:0] cand;
  logic        rejected;
  logic        moved;

  assign event_ready = !out_valid || out_ready;
  assign load        = frame_event.valid && event_ready;
  assign raw         = frame_event.position;

  // the three distances are formed side by side, then selected
  always_comb begin
    diff_last_raw   = (last_accepted > raw) ? last_accepted - raw : raw - last_accepted;
    diff_shown_raw  = (shown_value > raw) ? shown_value - raw : raw - shown_value;
    diff_shown_last = (shown_value > last_accepted) ? shown_value - last_accepted
                                                    : last_accepted - shown_value;
    rejected  = (last_accepted != 32'd0) && (diff_last_raw > {8'd0, cfg.jump_limit});
    cand      = rejected ? last_accepted : raw;
    diff_cand = rejected ? diff_shown_last : diff_shown_raw;
    moved     = diff_cand > {16'd0, cfg.noise_tolerance};
  end

  always_comb begin
    last_accepted_next = last_accepted;
    shown_value_next   = shown_value;
    filter_out_next.raw_position = 32'd0;
    unique case (frame_event.kind)
      efpf_pkg::FR_GOOD: begin
        last_accepted_next           = cand;
        shown_value_next             = moved ? cand : shown_value;
        filter_out_next.raw_position = raw;
        if (rejected) begin
          filter_out_next.status = efpf_pkg::ST_JUMP;
        end else if (moved) begin
          filter_out_next.status = efpf_pkg::ST_UPDATED;
        end else begin
          filter_out_next.status = efpf_pkg::ST_DEADBAND;
        end
      end
      efpf_pkg::FR_SHORT: begin
        filter_out_next.status = efpf_pkg::ST_SHORT;
      end
      default: begin
        filter_out_next.status = efpf_pkg::ST_NO_START;
      end
    endcase
    filter_out_next.shown_position = shown_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted <= 32'd0;
      shown_value   <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      if (load) begin
        last_accepted <= last_accepted_next;
        shown_value   <= shown_value_next;
        filter_out    <= filter_out_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frames without a position leave the filter history alone
  assert property (@(posedge clk) disable iff (rst)
    load && frame_event.kind != efpf_pkg::FR_GOOD
      |=> $stable(shown_value) && $stable(last_accepted))
    else $error("filter history changed by an undecoded frame");

  // undecoded frames report a zero raw position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (filter_out.status == efpf_pkg::ST_NO_START ||
                  filter_out.status == efpf_pkg::ST_SHORT)
      |-> filter_out.raw_position == 32'd0)
    else $error("raw position set on an undecoded frame");

endmodule

// ===== sv/efpf_angle.sv =====
// four-stage fixed-point angle conversion with single wrap and clamp
module efpf_angle (
  input  logic                   clk,
  input  logic                   rst,
  input  efpf_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  efpf_pkg::filter_out_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output efpf_pkg::result_item_t out_data
);

  localparam int AW = 43;

  logic valid_a, valid_b, valid_c;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  efpf_pkg::filter_out_t data_a, data_b, data_c;
  logic [31:0]          mag_a;
  logic                 neg_a, neg_b;
  logic [55:0]          prod_b;
  logic signed [AW-1:0] ang_c;

  logic [33:0]          diff_next;
  logic [33:0]          diff_neg;
  logic [31:0]          mag_next;
  logic [55:0]          prod_next;
  logic [56:0]          rounded;
  logic signed [AW-1:0] m_s;
  logic signed [AW-1:0] off_s;
  logic signed [AW-1:0] ang_next;
  logic signed [AW-1:0] span_s;
  logic signed [AW-1:0] wrapped;
  logic [18:0]          angle_next;

  assign rdy_d    = !out_valid || out_ready;
  assign rdy_c    = !valid_c || rdy_d;
  assign rdy_b    = !valid_b || rdy_c;
  assign rdy_a    = !valid_a || rdy_b;
  assign in_ready = rdy_a;

  // stage a: signed distance from home and its magnitude
  always_comb begin
    diff_next = {10'd0, cfg.home_ticks} - {2'd0, in_data.shown_position};
    diff_neg  = -diff_next;
    mag_next  = diff_next[33] ? diff_neg[31:0] : diff_next[31:0];
  end

  // stage b: scale multiply
  assign prod_next = mag_a * cfg.scale_q16;

  // stage c: round off q16, apply sign and offset
  always_comb begin
    rounded  = {1'b0, prod_b} + 57'd32768;
    m_s      = $signed({2'b00, rounded[56:16]});
    off_s    = $signed({{(AW - 21){cfg.offset_mdeg[20]}}, cfg.offset_mdeg});
    ang_next = (cfg.axis_mode || neg_b) ? off_s - m_s : off_s + m_s;
  end

  // stage d: one wrap then clamp into range
  always_comb begin
    span_s = $signed({{(AW - 19){1'b0}}, cfg.wrap_span_mdeg});
    priority if (ang_c > span_s) begin
      wrapped = ang_c - span_s;
    end else if (ang_c < $signed({AW{1'b0}})) begin
      wrapped = ang_c + span_s;
    end else begin
      wrapped = ang_c;
    end
    priority if (wrapped < $signed({AW{1'b0}})) begin
      angle_next = 19'd0;
    end else if (wrapped > $signed({{(AW - 19){1'b0}}, efpf_pkg::ANGLE_MAX})) begin
      angle_next = efpf_pkg::ANGLE_MAX;
    end else begin
      angle_next = wrapped[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) begin
        valid_a <= in_valid;
        data_a  <= in_data;
        mag_a   <= mag_next;
        neg_a   <= diff_next[33];
      end
      if (rdy_b) begin
        valid_b <= valid_a;
        data_b  <= data_a;
        prod_b  <= prod_next;
        neg_b   <= neg_a;
      end
      if (rdy_c) begin
        valid_c <= valid_b;
        data_c  <= data_b;
        ang_c   <= ang_next;
      end
      if (rdy_d) begin
        out_valid               <= valid_c;
        out_data.status         <= data_c.status;
        out_data.raw_position   <= data_c.raw_position;
        out_data.shown_position <= data_c.shown_position;
        out_data.angle_mdeg     <= angle_next;
      end
    end
  end

  // delivered angle never leaves the clamp range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.angle_mdeg <= efpf_pkg::ANGLE_MAX)
    else $error("angle outside clamp range");

endmodule

// ===== sv/encoder_frame_position_filter_unit.sv =====
// top level of the encoder frame position filter: registers, framing, filter, angle
//
// Takes the byte stream of an absolute encoder response, one byte per transfer,
// and yields one result per finished frame. A byte with new_response set opens a
// frame (and silently drops a frame still open); bytes are stored from the start
// byte 0x47 on, and the frame closes at a line feed or after MAX_FRAME_BYTES
// bytes. Bytes 2 to 5 of the stored frame form a big-endian position which
// passes a jump filter against the last accepted value, a deadband against the
// shown value, and a Q16 scale to millidegrees with one wrap and a clamp to
// 0..360000. Frames with no start byte or with fewer than six stored bytes are
// reported by status and leave the filter untouched. A byte is taken in every
// cycle unless byte_stall is raised; result_valid rises once the closing byte
// has passed the frame register, the filter register and the four angle stages
// (distance, multiply, round and offset, wrap and clamp). Results may follow one
// another every cycle while result_stall is low, and the pipeline keeps taking
// bytes while a result waits on a stalled output until all stages are full.
// Configuration is written through cfg_write/cfg_index/cfg_data and takes effect
// at once; indexes beyond the register list are ignored.
module encoder_frame_position_filter_unit #(
  parameter int MAX_FRAME_BYTES = efpf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  efpf_pkg::byte_item_t                byte_data,
  output logic                                result_valid,
  input  logic                                result_stall,
  output efpf_pkg::result_item_t              result_data,
  input  logic                                cfg_write,
  input  logic [efpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [efpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  efpf_pkg::cfg_t         cfg;
  efpf_pkg::frame_event_t frame_event;
  efpf_pkg::filter_out_t  filter_out;
  logic                   event_ready;
  logic                   filter_valid;
  logic                   angle_ready;

  // configuration registers, plain write port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_mode       <= efpf_pkg::AXIS_MODE_RST;
      cfg.home_ticks      <= efpf_pkg::HOME_TICKS_RST;
      cfg.scale_q16       <= efpf_pkg::SCALE_Q16_RST;
      cfg.offset_mdeg     <= efpf_pkg::OFFSET_RST;
      cfg.wrap_span_mdeg  <= efpf_pkg::WRAP_SPAN_RST;
      cfg.jump_limit      <= efpf_pkg::JUMP_LIMIT_RST;
      cfg.noise_tolerance <= efpf_pkg::NOISE_TOL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        efpf_pkg::REG_AXIS_MODE:  cfg.axis_mode       <= cfg_data[0];
        efpf_pkg::REG_HOME_TICKS: cfg.home_ticks      <= cfg_data[23:0];
        efpf_pkg::REG_SCALE_Q16:  cfg.scale_q16       <= cfg_data[23:0];
        efpf_pkg::REG_OFFSET:     cfg.offset_mdeg     <= cfg_data[20:0];
        efpf_pkg::REG_WRAP_SPAN:  cfg.wrap_span_mdeg  <= cfg_data[18:0];
        efpf_pkg::REG_JUMP_LIMIT: cfg.jump_limit      <= cfg_data[23:0];
        efpf_pkg::REG_NOISE_TOL:  cfg.noise_tolerance <= cfg_data[15:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // framing: one byte per cycle unless byte_stall is raised, raises a frame end event
  efpf_frame #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .event_ready (event_ready),
    .frame_event (frame_event)
  );

  // jump filter and deadband, holds last accepted and shown values
  efpf_filter u_filter (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_event (frame_event),
    .event_ready (event_ready),
    .out_valid   (filter_valid),
    .out_ready   (angle_ready),
    .filter_out  (filter_out)
  );

  // angle of the shown value, output register at its end
  efpf_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (filter_valid),
    .in_ready  (angle_ready),
    .in_data   (filter_out),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .out_data  (result_data)
  );

endmodule
